>>> hw/rtl/wsfd_pkg.sv
// Shared types, constants and helper functions for the weather-station frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package wsfd_pkg;

   localparam int unsigned POS_W     = 5;
   localparam logic [4:0]  FRAME_LEN = 5'd17;
   localparam logic [4:0]  FRAME_LAST = 5'd16;
   localparam logic [4:0]  CRC_LAST   = 5'd14;
   localparam logic [4:0]  SUM_LAST   = 5'd15;
   localparam logic [4:0]  LUX_FIRST  = 5'd12;
   localparam logic [4:0]  LUX_LAST   = 5'd14;

   localparam logic [7:0]  CRC_POLY    = 8'h31;
   localparam logic [11:0] TEMP_OFFSET = 12'd400;
   localparam logic [12:0] RECIP_TEN   = 13'd6554;   // round(2^16 / 10)
   localparam logic [11:0] DIV_BASE    = 12'd10;

   localparam logic [15:0] WIND_GAIN_RESET  = 16'd4221;
   localparam logic [15:0] GUST_GAIN_RESET  = 16'd33423;
   localparam logic [15:0] RAIN_GAIN_RESET  = 16'd16646;
   localparam logic [15:0] SOLAR_GAIN_RESET = 16'd517;

   localparam int unsigned UV_STEP_COUNT = 15;
   localparam logic [15:0] UV_STEPS [UV_STEP_COUNT] = '{
      16'd99,   16'd540,  16'd1000, 16'd1400, 16'd1843,
      16'd2292, 16'd2734, 16'd3138, 16'd3648, 16'd4196,
      16'd4707, 16'd5209, 16'd5735, 16'd6276, 16'd6778
   };

   typedef enum logic [1:0] {
      REG_WIND_GAIN  = 2'd0,
      REG_GUST_GAIN  = 2'd1,
      REG_RAIN_GAIN  = 2'd2,
      REG_SOLAR_GAIN = 2'd3
   } reg_index_type;

   typedef logic [POS_W-1:0] pos_type;

   typedef logic [15:1][7:0] frame_bytes_type;

   typedef struct packed {
      logic [15:0] wind;
      logic [15:0] gust;
      logic [15:0] rain;
      logic [15:0] solar;
   } gains_type;

   typedef struct packed {
      logic [20:0] lux;
      logic        crc_bad;
      logic        sum_bad;
   } acc_view_type;

   typedef struct packed {
      logic [7:0] quot;
      logic [3:0] rem;
   } div_step_type;

   typedef struct packed {
      logic [7:0]         node_id;
      logic [8:0]         wind_direction;
      logic signed [11:0] temp_tenths;
      logic [7:0]         humidity;
      logic [17:0]        wind_speed_q8;
      logic [15:0]        gust_q8;
      logic [23:0]        rain_q8;
      logic [15:0]        uv_raw;
      logic [3:0]         uv_step;
      logic [20:0]        light_lux;
      logic [28:0]        solar_q8;
      logic [1:0]         check_status;
   } record_type;

   // One byte through CRC-8, MSB first, no reflection.
   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // Count of thresholds at or below the reading.
   function automatic logic [3:0] uv_grade(input logic [15:0] uv);
      logic [3:0] idx;
      idx = 4'd0;
      for (int k = 0; k < UV_STEP_COUNT; k++) begin
         idx = idx + 4'(uv >= UV_STEPS[k]);
      end
      return idx;
   endfunction

   // One base-256 digit of long division by ten; v stays below 2560.
   function automatic div_step_type div10_step(input logic [11:0] v);
      div_step_type r;
      logic [24:0]  prod;
      logic [11:0]  back;
      logic [11:0]  diff;
      prod   = 25'(v) * 25'(RECIP_TEN);
      r.quot = prod[23:16];
      back   = {4'b0, r.quot} * DIV_BASE;
      diff   = v - back;
      r.rem  = diff[3:0];
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/weather_station_frame_decoder.sv
// Top level of the weather-station frame decoder: framing, decode and result register.
`timescale 1ns / 1ps
`default_nettype none
//
// Usage
//   req_*  : one frame byte per word (req_frame_byte, req_frame_start). A word is taken
//            at a clock edge with req_valid high and req_stall low. req_frame_start
//            high makes the word byte 0 of a new frame and drops any partial frame;
//            without it words are framed in groups of 17 counted from reset.
//   rsp_*  : one decoded record per 17-byte frame, on the word holding byte 16.
//            A nonzero rsp_check_status marks a frame whose CRC or sum failed.
//   csr_*  : APB-style port for the four Q16 gains (byte addresses 0, 4, 8, 12).
// Timing
//   A new word may follow in every cycle while req_stall is low. The record shows
//   on rsp_valid in the cycle after its last byte is taken. Gain products are
//   formed combinationally from the stored frame bytes; lux / 10 is worked out
//   one base-256 digit per byte as bytes 12 to 14 arrive.
// Stall and reset
//   A waiting record does not hold up words in the middle of a frame; only the
//   last byte of the next frame is stalled while a record is still held and
//   rsp_stall is high. Reset clears the byte position, the running CRC and sum,
//   the record valid flag, and loads the gain reset values.

module weather_station_frame_decoder (
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_frame_byte,
   input  wire logic               req_frame_start,

   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_node_id,
   output logic [8:0]              rsp_wind_direction,
   output logic signed [11:0]      rsp_temp_tenths,
   output logic [7:0]              rsp_humidity,
   output logic [17:0]             rsp_wind_speed_q8,
   output logic [15:0]             rsp_gust_q8,
   output logic [23:0]             rsp_rain_q8,
   output logic [15:0]             rsp_uv_raw,
   output logic [3:0]              rsp_uv_step,
   output logic [20:0]             rsp_light_lux,
   output logic [28:0]             rsp_solar_q8,
   output logic [1:0]              rsp_check_status,

   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [3:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   wsfd_pkg::gains_type       gains;
   wsfd_pkg::frame_bytes_type frame_bytes;
   wsfd_pkg::acc_view_type    view;
   wsfd_pkg::record_type      rec;
   wsfd_pkg::record_type      rec_ff;
   logic                      ends_frame;
   logic                      accept;
   logic                      load;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;

   wsfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gains       (gains)
   );

   wsfd_frame_acc u_acc (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_byte  (req_frame_byte),
      .frame_start (req_frame_start),
      .ends_frame  (ends_frame),
      .frame_bytes (frame_bytes),
      .view        (view)
   );

   wsfd_decode u_decode (
      .frame_bytes (frame_bytes),
      .view        (view),
      .gains       (gains),
      .rec         (rec)
   );

   // Hold the last byte only when the record register cannot be freed this cycle.
   assign req_stall    = ends_frame & rsp_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign load         = accept & ends_frame;
   assign rsp_valid_in = load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Record payload: load on the last byte, otherwise hold.
   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff <= rec;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_node_id        = rec_ff.node_id;
   assign rsp_wind_direction = rec_ff.wind_direction;
   assign rsp_temp_tenths    = rec_ff.temp_tenths;
   assign rsp_humidity       = rec_ff.humidity;
   assign rsp_wind_speed_q8  = rec_ff.wind_speed_q8;
   assign rsp_gust_q8        = rec_ff.gust_q8;
   assign rsp_rain_q8        = rec_ff.rain_q8;
   assign rsp_uv_raw         = rec_ff.uv_raw;
   assign rsp_uv_step        = rec_ff.uv_step;
   assign rsp_light_lux      = rec_ff.light_lux;
   assign rsp_solar_q8       = rec_ff.solar_q8;
   assign rsp_check_status   = rec_ff.check_status;

endmodule

`default_nettype wire

>>> hw/rtl/wsfd_csr.sv
// APB-style register file holding the four Q16 gains.
`timescale 1ns / 1ps
`default_nettype none

module wsfd_csr (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [3:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic      [31:0]        csr_prdata,
   output logic                    csr_pready,
   output wsfd_pkg::gains_type     gains
);

   wsfd_pkg::gains_type   gains_ff;
   wsfd_pkg::reg_index_type sel;
   logic                  wr_en;

   assign sel        = wsfd_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign gains      = gains_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.wind  <= wsfd_pkg::WIND_GAIN_RESET;
         gains_ff.gust  <= wsfd_pkg::GUST_GAIN_RESET;
         gains_ff.rain  <= wsfd_pkg::RAIN_GAIN_RESET;
         gains_ff.solar <= wsfd_pkg::SOLAR_GAIN_RESET;
      end else if (wr_en) begin
         unique case (sel)
            wsfd_pkg::REG_WIND_GAIN:  gains_ff.wind  <= csr_pwdata[15:0];
            wsfd_pkg::REG_GUST_GAIN:  gains_ff.gust  <= csr_pwdata[15:0];
            wsfd_pkg::REG_RAIN_GAIN:  gains_ff.rain  <= csr_pwdata[15:0];
            wsfd_pkg::REG_SOLAR_GAIN: gains_ff.solar <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         wsfd_pkg::REG_WIND_GAIN:  csr_prdata = {16'b0, gains_ff.wind};
         wsfd_pkg::REG_GUST_GAIN:  csr_prdata = {16'b0, gains_ff.gust};
         wsfd_pkg::REG_RAIN_GAIN:  csr_prdata = {16'b0, gains_ff.rain};
         wsfd_pkg::REG_SOLAR_GAIN: csr_prdata = {16'b0, gains_ff.solar};
         default:                  csr_prdata = 32'b0;
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/wsfd_frame_acc.sv
// Per-word framing: byte position, running CRC and sum, frame bytes, lux digits.
`timescale 1ns / 1ps
`default_nettype none

module wsfd_frame_acc (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            frame_byte,
   input  wire logic                  frame_start,
   output logic                       ends_frame,
   output wsfd_pkg::frame_bytes_type  frame_bytes,
   output wsfd_pkg::acc_view_type     view
);

   wsfd_pkg::pos_type         pos_ff;
   wsfd_pkg::pos_type         pos_in;
   wsfd_pkg::pos_type         pos;
   logic [7:0]                crc_ff;
   logic [7:0]                crc_in;
   logic [7:0]                sum_ff;
   logic [7:0]                sum_in;
   logic [7:0]                crc_base;
   logic [7:0]                sum_base;
   wsfd_pkg::frame_bytes_type frame_ff;
   logic [20:0]               lux_ff;
   logic [3:0]                rem_ff;
   logic                      lux_digit;
   wsfd_pkg::div_step_type    digit;

   always_comb begin
      pos = frame_start ? '0 : pos_ff;
      if (pos >= wsfd_pkg::FRAME_LEN) begin
         pos = '0;
      end
      crc_base   = (pos == '0) ? 8'd0 : crc_ff;
      sum_base   = (pos == '0) ? 8'd0 : sum_ff;
      crc_in     = (pos <= wsfd_pkg::CRC_LAST) ? wsfd_pkg::crc8_feed(crc_base, frame_byte)
                                               : crc_base;
      sum_in     = (pos <= wsfd_pkg::SUM_LAST) ? sum_base + frame_byte : sum_base;
      ends_frame = (pos == wsfd_pkg::FRAME_LAST);
      pos_in     = ends_frame ? '0 : pos + 5'd1;
      lux_digit  = (pos >= wsfd_pkg::LUX_FIRST) && (pos <= wsfd_pkg::LUX_LAST);
      digit      = wsfd_pkg::div10_step({(pos == wsfd_pkg::LUX_FIRST) ? 4'd0 : rem_ff,
                                         frame_byte});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         crc_ff <= '0;
         sum_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         sum_ff <= sum_in;
      end
   end

   // Frame bytes and lux digits carry no reset.
   always_ff @(posedge clock) begin
      for (int i = 1; i <= 15; i++) begin
         if (accept && (pos == 5'(i))) begin
            frame_ff[i] <= frame_byte;
         end
      end
      if (accept && lux_digit) begin
         lux_ff <= {lux_ff[12:0], digit.quot};
         rem_ff <= digit.rem;
      end
   end

   assign frame_bytes  = frame_ff;
   assign view.lux     = lux_ff;
   assign view.crc_bad = (frame_ff[15] != crc_base);
   assign view.sum_bad = (frame_byte != sum_base);

endmodule

`default_nettype wire

>>> hw/rtl/wsfd_decode.sv
// Field extraction and gain scaling of one completed frame.
`timescale 1ns / 1ps
`default_nettype none

module wsfd_decode (
   input  wire wsfd_pkg::frame_bytes_type frame_bytes,
   input  wire wsfd_pkg::acc_view_type    view,
   input  wire wsfd_pkg::gains_type       gains,
   output wsfd_pkg::record_type           rec
);

   logic [7:0]  f3;
   logic [9:0]  ws_raw;
   logic [11:0] temp_code;
   logic [15:0] rain_raw;
   logic [15:0] uv;
   logic [25:0] ws_prod;
   logic [23:0] gust_prod;
   logic [31:0] rain_prod;
   logic [36:0] solar_prod;

   always_comb begin
      f3         = frame_bytes[3];
      // flag bit set: 9-bit speed, else 10-bit
      ws_raw     = f3[6] ? {1'b0, f3[4], frame_bytes[6]} : {f3[5:4], frame_bytes[6]};
      temp_code  = {1'b0, f3[2:0], frame_bytes[4]};
      rain_raw   = {frame_bytes[8], frame_bytes[9]};
      uv         = {frame_bytes[10], frame_bytes[11]};
      ws_prod    = 26'(ws_raw) * 26'(gains.wind);
      gust_prod  = 24'(frame_bytes[7]) * 24'(gains.gust);
      rain_prod  = 32'(rain_raw) * 32'(gains.rain);
      solar_prod = 37'(view.lux) * 37'(gains.solar);

      rec.node_id        = frame_bytes[1];
      rec.wind_direction = {f3[7], frame_bytes[2]};
      rec.temp_tenths    = $signed(temp_code - wsfd_pkg::TEMP_OFFSET);
      rec.humidity       = frame_bytes[5];
      rec.wind_speed_q8  = ws_prod[25:8];
      rec.gust_q8        = gust_prod[23:8];
      rec.rain_q8        = rain_prod[31:8];
      rec.uv_raw         = uv;
      rec.uv_step        = wsfd_pkg::uv_grade(uv);
      rec.light_lux      = view.lux;
      rec.solar_q8       = solar_prod[36:8];
      rec.check_status   = {view.sum_bad, view.crc_bad};
   end

endmodule

`default_nettype wire

>>> hw/rtl/wsfd_checker.sv
// Port-level checker for the weather-station frame decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module wsfd_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [7:0]         rsp_node_id,
   input wire logic signed [11:0] rsp_temp_tenths,
   input wire logic [1:0]         rsp_check_status
);

   // A held record keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_node_id)
                                 && $stable(rsp_check_status))
      else $error("record changed while stalled");

   // A record appears only after a word was taken.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("record without a preceding word");

   // Input is held back only while a record waits on a stalled receiver.
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with no record waiting");

   // A taken record is not repeated unless a new word arrived.
   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !(req_valid && !req_stall) |=> !rsp_valid)
      else $error("record repeated");

   // Temperature never falls below the raw offset.
   a_temp_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_temp_tenths >= -12'sd400)
      else $error("temperature below offset");

endmodule

bind weather_station_frame_decoder wsfd_checker u_checker (.*);

`default_nettype wire

>>> dv/weather_station_frame_decoder_checker.sv
// Frame CRC helper and the record checker for the weather-station frame decoder testbench.
`timescale 1ns / 1ps

package wsfd_check_pkg;

   localparam logic [7:0] FRAME_POLY = 8'h31;

   // CRC-8 over one byte, MSB first, no reflection, no final xor.
   function automatic logic [7:0] crc_add_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      int         k;
      c = crc ^ b;
      for (k = 0; k < 8; k++) begin
         c = {c[6:0], 1'b0} ^ (c[7] ? FRAME_POLY : 8'h00);
      end
      return c;
   endfunction

endpackage

module weather_station_frame_decoder_checker (
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic [7:0]         req_frame_byte,
   input  wire logic               req_frame_start,

   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic [7:0]         rsp_node_id,
   input  wire logic [8:0]         rsp_wind_direction,
   input  wire logic signed [11:0] rsp_temp_tenths,
   input  wire logic [7:0]         rsp_humidity,
   input  wire logic [17:0]        rsp_wind_speed_q8,
   input  wire logic [15:0]        rsp_gust_q8,
   input  wire logic [23:0]        rsp_rain_q8,
   input  wire logic [15:0]        rsp_uv_raw,
   input  wire logic [3:0]         rsp_uv_step,
   input  wire logic [20:0]        rsp_light_lux,
   input  wire logic [28:0]        rsp_solar_q8,
   input  wire logic [1:0]         rsp_check_status,

   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [3:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   input  wire logic               csr_pready,

   output int unsigned             mismatch_count,
   output int unsigned             records_open
);

   // UV thresholds, lowest in the low slice.
   localparam logic [239:0] UV_LIMITS = {
      16'd6778, 16'd6276, 16'd5735, 16'd5209, 16'd4707, 16'd4196, 16'd3648, 16'd3138,
      16'd2734, 16'd2292, 16'd1843, 16'd1400, 16'd1000, 16'd540,  16'd99
   };

   logic [4:0]  word_pos;
   logic [7:0]  run_crc;
   logic [7:0]  run_sum;
   logic [7:0]  frame_img [17];
   logic [15:0] wind_gain;
   logic [15:0] gust_gain;
   logic [15:0] rain_gain;
   logic [15:0] solar_gain;
   wsfd_pkg::record_type expected_records [$];
   int unsigned error_tally = 0;

   function automatic logic [3:0] uv_level(input logic [15:0] uv);
      logic [3:0] n;
      int         k;
      n = 4'd0;
      for (k = 0; k < 15; k++) begin
         if (uv >= UV_LIMITS[k*16 +: 16]) begin
            n = n + 4'd1;
         end
      end
      return n;
   endfunction

   // Decode the stored frame under the current gains.
   function automatic wsfd_pkg::record_type decode_frame();
      wsfd_pkg::record_type r;
      logic [9:0]  speed_raw;
      logic [10:0] temp_code;
      logic [15:0] uv;
      logic [20:0] lux;
      logic [63:0] prod;
      r.node_id        = frame_img[1];
      r.wind_direction = {frame_img[3][7], frame_img[2]};
      temp_code        = {frame_img[3][2:0], frame_img[4]};
      r.temp_tenths    = 12'(temp_code) - 12'd400;
      r.humidity       = frame_img[5];
      // flag bit picks a 9-bit or a 10-bit raw speed
      speed_raw = frame_img[3][6] ? {1'b0, frame_img[3][4], frame_img[6]}
                                  : {frame_img[3][5:4], frame_img[6]};
      prod            = 64'(speed_raw) * 64'(wind_gain);
      r.wind_speed_q8 = prod[25:8];
      prod            = 64'(frame_img[7]) * 64'(gust_gain);
      r.gust_q8       = prod[23:8];
      prod            = 64'({frame_img[8], frame_img[9]}) * 64'(rain_gain);
      r.rain_q8       = prod[31:8];
      uv              = {frame_img[10], frame_img[11]};
      r.uv_raw        = uv;
      r.uv_step       = uv_level(uv);
      lux             = 21'({frame_img[12], frame_img[13], frame_img[14]} / 24'd10);
      r.light_lux     = lux;
      prod            = 64'(lux) * 64'(solar_gain);
      r.solar_q8      = prod[36:8];
      r.check_status  = {frame_img[16] != run_sum, frame_img[15] != run_crc};
      return r;
   endfunction

   // Advance the framing state by one accepted word.
   function automatic void take_word(input logic [7:0] b, input logic start);
      if (start) begin
         word_pos = 5'd0;
      end
      if (word_pos == 5'd0) begin
         run_crc = 8'h00;
         run_sum = 8'h00;
      end
      frame_img[word_pos] = b;
      if (word_pos <= 5'd14) begin
         run_crc = wsfd_check_pkg::crc_add_byte(run_crc, b);
      end
      if (word_pos <= 5'd15) begin
         run_sum = run_sum + b;
      end
      if (word_pos < 5'd16) begin
         word_pos = word_pos + 5'd1;
      end else begin
         word_pos = 5'd0;
         expected_records.push_back(decode_frame());
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         error_tally++;
         if (error_tally <= 10) begin
            $display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
         end
      end
   endfunction

   always @(posedge clock) begin
      wsfd_pkg::record_type want;
      if (reset) begin
         word_pos   = 5'd0;
         run_crc    = 8'h00;
         run_sum    = 8'h00;
         wind_gain  = 16'd4221;
         gust_gain  = 16'd33423;
         rain_gain  = 16'd16646;
         solar_gain = 16'd517;
         expected_records.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               wsfd_pkg::REG_WIND_GAIN:  wind_gain  = csr_pwdata[15:0];
               wsfd_pkg::REG_GUST_GAIN:  gust_gain  = csr_pwdata[15:0];
               wsfd_pkg::REG_RAIN_GAIN:  rain_gain  = csr_pwdata[15:0];
               wsfd_pkg::REG_SOLAR_GAIN: solar_gain = csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            take_word(req_frame_byte, req_frame_start);
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_records.size() == 0) begin
               error_tally++;
               if (error_tally <= 10) begin
                  $display("%0t ns: record with none expected, node %0h", $time, rsp_node_id);
               end
            end else begin
               want = expected_records.pop_front();
               check_field("node_id",        want.node_id,        rsp_node_id);
               check_field("wind_direction", want.wind_direction, rsp_wind_direction);
               check_field("temp_tenths",    want.temp_tenths,    rsp_temp_tenths);
               check_field("humidity",       want.humidity,       rsp_humidity);
               check_field("wind_speed_q8",  want.wind_speed_q8,  rsp_wind_speed_q8);
               check_field("gust_q8",        want.gust_q8,        rsp_gust_q8);
               check_field("rain_q8",        want.rain_q8,        rsp_rain_q8);
               check_field("uv_raw",         want.uv_raw,         rsp_uv_raw);
               check_field("uv_step",        want.uv_step,        rsp_uv_step);
               check_field("light_lux",      want.light_lux,      rsp_light_lux);
               check_field("solar_q8",       want.solar_q8,       rsp_solar_q8);
               check_field("check_status",   want.check_status,   rsp_check_status);
            end
         end
      end
      mismatch_count <= error_tally;
      records_open   <= expected_records.size();
   end

endmodule

>>> dv/weather_station_frame_decoder_tb.sv
// Testbench top for the weather-station frame decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module weather_station_frame_decoder_tb;

   localparam int unsigned PHASE_WORDS    = 250;   // words per gain setting
   localparam int unsigned PHASE_COUNT    = 6;
   localparam int unsigned LONG_HOLD      = 300;   // receiver hold-off, in cycles
   localparam int unsigned HOLD_AT_RECORD = 20;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned DRAIN_LIMIT    = 5000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;

   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_frame_byte;
   logic               req_frame_start;

   logic               rsp_valid;
   logic               rsp_stall;
   logic [7:0]         rsp_node_id;
   logic [8:0]         rsp_wind_direction;
   logic signed [11:0] rsp_temp_tenths;
   logic [7:0]         rsp_humidity;
   logic [17:0]        rsp_wind_speed_q8;
   logic [15:0]        rsp_gust_q8;
   logic [23:0]        rsp_rain_q8;
   logic [15:0]        rsp_uv_raw;
   logic [3:0]         rsp_uv_step;
   logic [20:0]        rsp_light_lux;
   logic [28:0]        rsp_solar_q8;
   logic [1:0]         rsp_check_status;

   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [3:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   int unsigned        mismatch_count;
   int unsigned        records_open;

   int unsigned        words_sent    = 0;
   int unsigned        records_taken = 0;
   bit                 tx_burst      = 1'b0;   // sender runs without gaps while set
   bit                 rx_burst      = 1'b0;   // receiver stalls only for the long hold while set
   bit                 hold_done     = 1'b0;
   bit                 frame_aligned = 1'b0;   // next unmarked word would be byte 0
   logic [7:0]         frame_img [17];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   weather_station_frame_decoder DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_frame_byte     (req_frame_byte),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_node_id        (rsp_node_id),
      .rsp_wind_direction (rsp_wind_direction),
      .rsp_temp_tenths    (rsp_temp_tenths),
      .rsp_humidity       (rsp_humidity),
      .rsp_wind_speed_q8  (rsp_wind_speed_q8),
      .rsp_gust_q8        (rsp_gust_q8),
      .rsp_rain_q8        (rsp_rain_q8),
      .rsp_uv_raw         (rsp_uv_raw),
      .rsp_uv_step        (rsp_uv_step),
      .rsp_light_lux      (rsp_light_lux),
      .rsp_solar_q8       (rsp_solar_q8),
      .rsp_check_status   (rsp_check_status),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   weather_station_frame_decoder_checker u_record_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_frame_byte     (req_frame_byte),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_node_id        (rsp_node_id),
      .rsp_wind_direction (rsp_wind_direction),
      .rsp_temp_tenths    (rsp_temp_tenths),
      .rsp_humidity       (rsp_humidity),
      .rsp_wind_speed_q8  (rsp_wind_speed_q8),
      .rsp_gust_q8        (rsp_gust_q8),
      .rsp_rain_q8        (rsp_rain_q8),
      .rsp_uv_raw         (rsp_uv_raw),
      .rsp_uv_step        (rsp_uv_step),
      .rsp_light_lux      (rsp_light_lux),
      .rsp_solar_q8       (rsp_solar_q8),
      .rsp_check_status   (rsp_check_status),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_pready         (csr_pready),
      .mismatch_count     (mismatch_count),
      .records_open       (records_open)
   );

   // Hard stop: far beyond the slowest legal run (every word and record at its
   // longest gap, plus the long receiver hold-off and the phase drains).
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Record receiver: draw a stall length per record, switch now and then into
   // a burst mode with no stalls, and hold off once for a long stretch so that
   // the decoder backs up and stalls its input.
   initial begin
      int unsigned gap;
      rsp_stall = 1'b1;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 63) == 0) begin
            rx_burst = !rx_burst;
         end
         gap = rx_burst ? 0 : $urandom_range(0, 16);
         if (records_taken == HOLD_AT_RECORD && !hold_done) begin
            gap       = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && !rsp_stall));
         records_taken++;
      end
   end

   // Offer one word; idle first for a drawn number of cycles with junk on the
   // payload, then hold the word until the decoder takes it.
   task automatic send_word(input logic [7:0] b, input logic start);
      int unsigned gap;
      if ($urandom_range(0, 63) == 0) begin
         tx_burst = !tx_burst;
      end
      gap = tx_burst ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_valid       <= 1'b0;
         req_frame_byte  <= 8'($urandom);
         req_frame_start <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_frame_byte  <= b;
      req_frame_start <= start;
      do @(posedge clock); while (!(req_valid && !req_stall));
      words_sent++;
   endtask

   // Send the first count bytes of the frame image; mark byte 0 if asked.
   task automatic send_frame(input logic marked, input int unsigned count);
      for (int k = 0; k < count; k++) begin
         send_word(frame_img[k], marked && k == 0);
      end
   endtask

   // Lean toward the byte extremes so that every decoded field reaches its ends.
   function automatic logic [7:0] any_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Fill the frame image with good CRC and sum; a flat frame repeats one value.
   function automatic void build_frame(input bit flat, input logic [7:0] flat_value);
      logic [7:0]  crc;
      logic [7:0]  sum;
      logic [15:0] uv;
      for (int k = 0; k < 15; k++) begin
         frame_img[k] = flat ? flat_value : any_byte();
      end
      // land the UV reading on or next to a threshold
      if (!flat && $urandom_range(0, 2) == 0) begin
         uv = wsfd_pkg::UV_STEPS[$urandom_range(0, wsfd_pkg::UV_STEP_COUNT - 1)]
              + 16'($urandom_range(0, 2)) - 16'd1;
         frame_img[10] = uv[15:8];
         frame_img[11] = uv[7:0];
      end
      crc = 8'h00;
      sum = 8'h00;
      for (int k = 0; k < 15; k++) begin
         crc = wsfd_check_pkg::crc_add_byte(crc, frame_img[k]);
         sum = sum + frame_img[k];
      end
      frame_img[15] = crc;
      frame_img[16] = sum + crc;
   endfunction

   // Break the CRC, the sum or both. The sum covers byte 15, so a CRC-only
   // error has to carry the change into the sum byte.
   function automatic void spoil_checks();
      logic [7:0] flip;
      logic [7:0] old_crc;
      flip    = 8'($urandom_range(1, 255));
      old_crc = frame_img[15];
      case ($urandom_range(0, 2))
         0: begin
            frame_img[15] = frame_img[15] ^ flip;
            frame_img[16] = frame_img[16] - old_crc + frame_img[15];
         end
         1: frame_img[16] = frame_img[16] ^ flip;
         default: frame_img[15] = frame_img[15] ^ flip;
      endcase
   endfunction

   // One APB write; psel stays high so that writes can run back to back.
   task automatic csr_write(input wsfd_pkg::reg_index_type idx, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'($urandom), value};   // upper half must be ignored
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // Write all four gains for a phase: all ones, all zeros, random, back to reset.
   task automatic load_gains(input int unsigned phase);
      wsfd_pkg::reg_index_type idx;
      logic [15:0]             value;
      for (int k = 0; k < 4; k++) begin
         idx = wsfd_pkg::reg_index_type'(k);
         case (phase)
            1: value = 16'hFFFF;
            2: value = 16'h0000;
            5: begin
               case (idx)
                  wsfd_pkg::REG_WIND_GAIN: value = wsfd_pkg::WIND_GAIN_RESET;
                  wsfd_pkg::REG_GUST_GAIN: value = wsfd_pkg::GUST_GAIN_RESET;
                  wsfd_pkg::REG_RAIN_GAIN: value = wsfd_pkg::RAIN_GAIN_RESET;
                  default:                 value = wsfd_pkg::SOLAR_GAIN_RESET;
               endcase
            end
            default: value = 16'($urandom);
         endcase
         csr_write(idx, value);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Drop valid, wait for every expected record, then let the pipeline settle.
   task automatic drain_records();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (records_open != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned phase_end;
      int unsigned kind;
      int unsigned burst_len;
      req_valid       = 1'b0;
      req_frame_byte  = 8'h00;
      req_frame_start = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = 4'h0;
      csr_pwdata      = 32'h0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Unmarked words right after reset start a frame at byte 0; a start mark
      // on the fifth word drops them. The marked frame carries every data byte
      // at its maximum, so the flag selects the 9-bit speed path, UV reaches
      // the top index and lux its largest value.
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h55, 1'b0);
      send_word(8'hAA, 1'b0);
      build_frame(1'b1, 8'hFF);
      send_frame(1'b1, 17);
      frame_aligned = 1'b1;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase != 0) begin
            // gains change only with the decoder idle
            drain_records();
            load_gains(phase);
            build_frame(1'b1, 8'hFF);
            send_frame(1'b1, 17);
            frame_aligned = 1'b1;
         end
         phase_end = (phase + 1) * PHASE_WORDS;
         while (words_sent < phase_end) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
               // well-formed frame, random content
               build_frame(1'b0, 8'h00);
               send_frame(1'b1, 17);
               frame_aligned = 1'b1;
            end else if (kind < 70) begin
               // rejected frame: record still comes, with a nonzero status
               build_frame(1'b0, 8'h00);
               spoil_checks();
               send_frame(1'b1, 17);
               frame_aligned = 1'b1;
            end else if (kind < 78) begin
               // cut short; the next start mark drops the partial frame
               build_frame(1'b0, 8'h00);
               send_frame(1'b1, $urandom_range(1, 16));
               frame_aligned = 1'b0;
            end else if (kind < 86) begin
               // frame with no start mark when aligned, relying on the 17-byte count
               build_frame(1'b0, 8'h00);
               send_frame(!frame_aligned, 17);
               frame_aligned = 1'b1;
            end else if (kind < 93) begin
               // all zeros or all ones, checks good
               build_frame(1'b1, $urandom_range(0, 1) ? 8'hFF : 8'h00);
               send_frame(1'b1, 17);
               frame_aligned = 1'b1;
            end else begin
               // noise: loose words with scattered start marks
               burst_len = $urandom_range(1, 6);
               repeat (burst_len) begin
                  send_word(8'($urandom), $urandom_range(0, 3) == 0);
               end
               frame_aligned = 1'b0;
            end
         end
      end

      drain_records();
      if (mismatch_count == 0 && records_open == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
